@@ sv/sks_pkg.sv @@
// sks_pkg: shared constants, command codes and the cell control struct
// for the sorted key set. No dependencies.
package sks_pkg;

  localparam int CAPACITY = 256;
  localparam int KEY_BITS = 32;

  // Port field widths fixed by the item format
  localparam int CMD_W         = 2;
  localparam int KEY_IN_W      = 32;
  localparam int ENTRY_COUNT_W = 9;

  // Internal widths
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int GROUP  = 16;
  localparam int NGROUP = (CAPACITY + GROUP - 1) / GROUP;

  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ERASE  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

  // Broadcast controls for the cell row
  typedef struct packed {
    logic cmp_en;      // register compare flags in every cell
    logic red_en;      // register group match flags
    logic shift_up;    // insert: open a gap at the lower bound
    logic shift_down;  // erase: close the gap at the lower bound
  } sks_ctl_t;

endpackage

@@ sv/sks_if.sv @@
// sks_if: valid/ready channel interfaces for requests and responses.
// Depends on sks_pkg for field widths.
interface sks_req_if;
  logic                               valid;
  logic                               ready;
  logic [sks_pkg::CMD_W-1:0]          command;
  logic [sks_pkg::KEY_IN_W-1:0]       key;

  modport source (output valid, output command, output key, input ready);
  modport sink   (input valid, input command, input key, output ready);
endinterface

interface sks_rsp_if;
  logic                               valid;
  logic                               ready;
  logic                               success;
  logic                               table_full;
  logic [sks_pkg::ENTRY_COUNT_W-1:0]  entry_count;

  modport source (output valid, output success, output table_full,
                  output entry_count, input ready);
  modport sink   (input valid, input success, input table_full,
                  input entry_count, output ready);
endinterface

@@ sv/sks_cell.sv @@
// sks_cell: one slot of the sorted row; holds a key, compares it with the
// broadcast key and shifts with its neighbors. Depends on sks_pkg.
module sks_cell (
  input  logic                          clk,
  input  sks_pkg::sks_ctl_t             ctl,
  input  logic                          occupied,
  input  logic [sks_pkg::KEY_BITS-1:0]  key,
  input  logic [sks_pkg::KEY_BITS-1:0]  left_entry,
  input  logic                          left_lt,
  input  logic [sks_pkg::KEY_BITS-1:0]  right_entry,
  output logic [sks_pkg::KEY_BITS-1:0]  entry,
  output logic                          lt,
  output logic                          eq
);
  import sks_pkg::*;

  logic [KEY_BITS-1:0] entry_next;

  // lt marks cells below the lower bound; left_lt high and lt low is the slot
  always_comb begin
    entry_next = entry;
    if (ctl.shift_up && !lt) begin
      entry_next = left_lt ? key : left_entry;
    end else if (ctl.shift_down && !lt) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
    if (ctl.cmp_en) begin
      lt <= occupied && (entry < key);
      eq <= occupied && (entry == key);
    end
  end

endmodule

@@ sv/sks_row.sv @@
// sks_row: chain of sks_cell slots plus the registered group-match stage.
// Depends on sks_pkg and sks_cell.
module sks_row (
  input  logic                          clk,
  input  sks_pkg::sks_ctl_t             ctl,
  input  logic [sks_pkg::CNT_W-1:0]     count,
  input  logic [sks_pkg::KEY_BITS-1:0]  key,
  output logic [sks_pkg::NGROUP-1:0]    grp_match
);
  import sks_pkg::*;

  logic [KEY_BITS-1:0]      entry [CAPACITY];
  logic [CAPACITY-1:0]      lt;
  logic [NGROUP*GROUP-1:0]  eq_pad;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_BITS-1:0] left_e;
    logic [KEY_BITS-1:0] right_e;
    logic                left_l;
    logic                occ;

    if (i == 0) begin : g_first
      assign left_e = key;
      assign left_l = 1'b1;
    end else begin : g_mid
      assign left_e = entry[i-1];
      assign left_l = lt[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_e = entry[i];
    end else begin : g_inner
      assign right_e = entry[i+1];
    end

    assign occ = CNT_W'(i) < count;

    sks_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occupied    (occ),
      .key         (key),
      .left_entry  (left_e),
      .left_lt     (left_l),
      .right_entry (right_e),
      .entry       (entry[i]),
      .lt          (lt[i]),
      .eq          (eq_pad[i])
    );
  end

  if (NGROUP * GROUP > CAPACITY) begin : g_pad
    assign eq_pad[NGROUP*GROUP-1:CAPACITY] = '0;
  end

  always_ff @(posedge clk) begin
    if (ctl.red_en) begin
      for (int g = 0; g < NGROUP; g++) begin
        grp_match[g] <= |eq_pad[g*GROUP +: GROUP];
      end
    end
  end

endmodule

@@ sv/sks_top_note.sv @@
// sks_out_reg: response holding register between the core and the
// response channel. Depends on sks_pkg and sks_if.
module sks_out_reg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               load,
  input  logic                               success,
  input  logic                               table_full,
  input  logic [sks_pkg::ENTRY_COUNT_W-1:0]  entry_count,
  output logic                               busy,
  sks_rsp_if.source                          rsp
);
  import sks_pkg::*;

  // busy: a response still waits and cannot be replaced this cycle
  assign busy = rsp.valid && !rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
    if (load) begin
      rsp.success     <= success;
      rsp.table_full  <= table_full;
      rsp.entry_count <= entry_count;
    end
  end

endmodule

@@ sv/sorted_key_set_core.sv @@
// sorted_key_set_core: sorted set of distinct keys held in a chain of cells.
// An accepted request moves through the registered compare, the two-level
// match reduction and the apply state before its response is valid; apply
// waits while an earlier response is still held. A new request is accepted
// only after the return to idle, so one request is processed at a time.
// Reset: synchronous; empties the set and drops any pending response.
module sorted_key_set_core (
  input  logic       clk,
  input  logic       rst,
  sks_req_if.sink    req,
  sks_rsp_if.source  rsp
);
  import sks_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_RED,
    S_APPLY
  } state_t;

  state_t                    state;
  logic [CMD_W-1:0]          cmd;
  logic [KEY_BITS-1:0]       key;
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          count_next;
  logic [NGROUP-1:0]         grp_match;
  sks_ctl_t                  ctl;
  logic                      found;
  logic                      is_full;
  logic                      apply_go;
  logic                      rsp_busy;
  logic                      res_success;
  logic                      res_full;

  // One request in flight; the response register frees the input side
  assign req.ready = (state == S_IDLE);

  assign found    = |grp_match;
  assign is_full  = (count == CNT_W'(CAPACITY));
  assign apply_go = (state == S_APPLY) && !rsp_busy;

  // Decide the outcome and which way the row shifts
  always_comb begin
    ctl            = '0;
    ctl.cmp_en     = (state == S_CMP);
    ctl.red_en     = (state == S_RED);
    count_next     = count;
    res_success    = 1'b0;
    res_full       = 1'b0;
    case (cmd)
      CMD_LOOKUP: begin
        res_success = found;
      end
      CMD_INSERT: begin
        if (!found && is_full) begin
          res_full = 1'b1;
        end else if (!found) begin
          res_success    = 1'b1;
          ctl.shift_up   = apply_go;
          count_next     = count + 1'b1;
        end
      end
      CMD_ERASE: begin
        if (found) begin
          res_success    = 1'b1;
          ctl.shift_down = apply_go;
          count_next     = count - 1'b1;
        end
      end
      CMD_CLEAR: begin
        res_success = 1'b1;
        count_next  = '0;
      end
      default: begin
        res_success = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_RED;
        end
        S_RED: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          if (apply_go) begin
            count <= count_next;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
    // Latch the request; keys compare on their low KEY_BITS bits
    if (state == S_IDLE && req.valid) begin
      cmd <= req.command;
      key <= KEY_BITS'(req.key);
    end
  end

  sks_row u_row (
    .clk       (clk),
    .ctl       (ctl),
    .count     (count),
    .key       (key),
    .grp_match (grp_match)
  );

  sks_out_reg u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (apply_go),
    .success     (res_success),
    .table_full  (res_full),
    .entry_count (ENTRY_COUNT_W'(count_next)),
    .busy        (rsp_busy),
    .rsp         (rsp)
  );

endmodule

@@ dv/sks_checker.sv @@
// sks_checker: watches the request and response channels of the sorted key
// set, keeps its own sorted copy of the set and compares every response.
// Depends on sks_pkg and the channel interfaces in sks_if.
module sks_checker (
  input  logic        clk,
  input  logic        rst,
  sks_req_if          req,
  sks_rsp_if          rsp,
  output int unsigned fail_count,
  output int unsigned outstanding
);
  import sks_pkg::*;

  typedef struct packed {
    logic                     success;
    logic                     table_full;
    logic [ENTRY_COUNT_W-1:0] entry_count;
  } set_result_t;

  logic [KEY_BITS-1:0] held_keys [CAPACITY];
  int unsigned         held_size;
  set_result_t         pending_results [$];
  set_result_t         want;

  initial begin
    fail_count  = 0;
    outstanding = 0;
    held_size   = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // Applies one request to the local set and returns the response it must cause.
  function automatic set_result_t apply_set_op(input logic [CMD_W-1:0]    cmd,
                                               input logic [KEY_IN_W-1:0] raw_key);
    logic [KEY_BITS-1:0] k;
    int unsigned         slot;
    bit                  hit;
    set_result_t         r;
    k    = raw_key[KEY_BITS-1:0];
    slot = 0;
    // lower bound: first entry not below the key
    while (slot < held_size && held_keys[slot] < k) slot++;
    hit = (slot < held_size) && (held_keys[slot] == k);
    r   = '0;
    case (cmd)
      CMD_LOOKUP: r.success = hit;
      CMD_INSERT: begin
        if (!hit) begin
          if (held_size >= CAPACITY) begin
            r.table_full = 1'b1;
          end else begin
            for (int i = int'(held_size); i > int'(slot); i--) held_keys[i] = held_keys[i-1];
            held_keys[slot] = k;
            held_size++;
            r.success = 1'b1;
          end
        end
      end
      CMD_ERASE: begin
        if (hit) begin
          for (int i = int'(slot); i + 1 < int'(held_size); i++) held_keys[i] = held_keys[i+1];
          held_size--;
          r.success = 1'b1;
        end
      end
      default: begin
        held_size = 0;
        r.success = 1'b1;
      end
    endcase
    r.entry_count = held_size[ENTRY_COUNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      pending_results.delete();
      held_size = 0;
    end else begin
      // response first: it is registered after the compare, match and apply
      // states, so it never belongs to a request accepted at this same edge
      if (rsp.valid && rsp.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("response with no request outstanding");
        end else begin
          want = pending_results.pop_front();
          if (rsp.success !== want.success)
            report_mismatch($sformatf("success got %0b expected %0b",
                                      rsp.success, want.success));
          if (rsp.table_full !== want.table_full)
            report_mismatch($sformatf("table_full got %0b expected %0b",
                                      rsp.table_full, want.table_full));
          if (rsp.entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count got %0d expected %0d",
                                      rsp.entry_count, want.entry_count));
        end
      end
      if (req.valid && req.ready)
        pending_results.push_back(apply_set_op(req.command, req.key));
    end
    outstanding <= pending_results.size();
  end

endmodule

@@ dv/tb_sorted_key_set_core.sv @@
// tb_sorted_key_set_core: drives requests into the sorted key set core with
// random idling on both channels and gives the verdict from the checker.
// Depends on sks_pkg, sks_if, sks_checker and sorted_key_set_core.
module tb_sorted_key_set_core;
  import sks_pkg::*;

  localparam int POOL_SIZE = 400;

  logic        clk;
  logic        rst;
  int unsigned fail_count;
  int unsigned outstanding;
  bit          idle_off;

  // Shared key pool: repeats make hits, duplicates and erases of held keys
  // likely. Entry 0 and 1 are the key extremes.
  logic [KEY_IN_W-1:0] key_pool [POOL_SIZE];

  sks_req_if req_ch ();
  sks_rsp_if rsp_ch ();

  sorted_key_set_core u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  sks_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Hard stop in case a handshake hangs.
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Response side: stalls ~38% of cycles unless idling is switched off.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst)
        rsp_ch.ready <= 1'b0;
      else if (idle_off)
        rsp_ch.ready <= 1'b1;
      else
        rsp_ch.ready <= ($urandom_range(0, 99) >= 38);
    end
  end

  // Presents one request, with optional random gaps before it, and returns
  // at the edge where it is accepted. valid stays high into the next request
  // when no gap is drawn.
  task automatic send_request(input logic [CMD_W-1:0]    cmd,
                              input logic [KEY_IN_W-1:0] k);
    if (!idle_off) begin
      while ($urandom_range(0, 99) < 38) begin
        req_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    req_ch.valid   <= 1'b1;
    req_ch.command <= cmd;
    req_ch.key     <= k;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Holds off the sender until every outstanding response has come back.
  // The first edge lets the checker count the last accepted request.
  task automatic drain_responses();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Random phase: command mix given in percent (clear takes the remainder),
  // keys from the first pool_n pool entries, with some fully random keys.
  task automatic run_phase(input int n, input int pool_n, input int pct_ins,
                           input int pct_look, input int pct_erase,
                           input bit wide_keys);
    int                  r;
    logic [CMD_W-1:0]    cmd;
    logic [KEY_IN_W-1:0] k;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < pct_ins)
        cmd = CMD_INSERT;
      else if (r < pct_ins + pct_look)
        cmd = CMD_LOOKUP;
      else if (r < pct_ins + pct_look + pct_erase)
        cmd = CMD_ERASE;
      else
        cmd = CMD_CLEAR;
      if (wide_keys || $urandom_range(0, 19) == 0)
        k = $urandom();
      else
        k = key_pool[$urandom_range(0, pool_n - 1)];
      send_request(cmd, k);
    end
    drain_responses();
  endtask

  initial begin
    rst            <= 1'b1;
    req_ch.valid   <= 1'b0;
    req_ch.command <= CMD_LOOKUP;
    req_ch.key     <= '0;
    idle_off        = 1'b0;

    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++)
      key_pool[i] = (i % 4 == 0) ? KEY_IN_W'(i) : $urandom();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty set behavior, key extremes, duplicates, absent erase,
    // neighbors of held keys, clear with and without entries.
    send_request(CMD_CLEAR,  32'h0000_0000);   // clear on empty set
    send_request(CMD_LOOKUP, 32'h0000_0000);
    send_request(CMD_ERASE,  32'hFFFF_FFFF);   // erase of absent key
    send_request(CMD_INSERT, 32'h0000_0000);
    send_request(CMD_INSERT, 32'hFFFF_FFFF);
    send_request(CMD_INSERT, 32'h0000_0000);   // duplicate insert
    send_request(CMD_INSERT, 32'h8000_0000);   // unsigned order around the MSB
    send_request(CMD_INSERT, 32'h7FFF_FFFF);
    send_request(CMD_LOOKUP, 32'h7FFF_FFFF);
    send_request(CMD_LOOKUP, 32'h7FFF_FFFE);   // neighbor, absent
    send_request(CMD_LOOKUP, 32'hFFFF_FFFF);
    send_request(CMD_ERASE,  32'h0000_0000);   // smallest entry
    send_request(CMD_ERASE,  32'h0000_0000);   // now absent
    send_request(CMD_ERASE,  32'hFFFF_FFFF);   // largest entry
    send_request(CMD_INSERT, 32'h5555_5555);
    send_request(CMD_INSERT, 32'hAAAA_AAAA);
    send_request(CMD_LOOKUP, 32'hAAAA_AAAA);
    send_request(CMD_CLEAR,  32'hFFFF_FFFF);   // clear with entries held
    send_request(CMD_LOOKUP, 32'h8000_0000);
    send_request(CMD_INSERT, 32'h0000_0001);
    send_request(CMD_CLEAR,  32'h1234_5678);
    drain_responses();

    // Fill toward capacity: full-table refusals and duplicates on a full set.
    run_phase(700, POOL_SIZE, 85, 8, 7, 1'b0);
    // Churn around the full boundary.
    run_phase(300, POOL_SIZE, 40, 30, 30, 1'b0);
    // Noise with fully random keys, no idling on either side.
    idle_off = 1'b1;
    run_phase(300, POOL_SIZE, 25, 25, 25, 1'b1);
    idle_off = 1'b0;
    // Small key pool: frequent hits, erases and clears.
    run_phase(300, 16, 30, 30, 30, 1'b0);
    // Refill after the clears.
    run_phase(200, POOL_SIZE, 90, 5, 5, 1'b0);

    // Nothing outstanding now; let the pipeline settle past its latency.
    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/sks_pkg.sv
sv/sks_if.sv
sv/sks_cell.sv
sv/sks_row.sv
sv/sks_top_note.sv
sv/sorted_key_set_core.sv
dv/sks_checker.sv
dv/tb_sorted_key_set_core.sv
